/* sv/uv_sphere_vertex_generator_top_defines.svh */
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shared property wrappers clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// ante true at an edge requires cons at the same edge
`define UVS_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uvs implication failed");

// expr must never hold
`define UVS_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("uvs forbidden condition seen");

`endif

/* sv/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared types, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int DIV_STEPS = 32;
   localparam int XY_W      = 34;
   localparam int Z_W       = 33;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic [15:0] U_OFFSET = 16'd2608;
   localparam logic [15:0] V_OFFSET = 16'd5215;

   typedef enum logic [1:0] {
      CSR_RADIUS      = 2'd0,
      CSR_STACK_COUNT = 2'd1,
      CSR_SLICE_COUNT = 2'd2
   } csr_index_type;

   // arctan(2^-k) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TABLE [0:23] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [7:0]  rem;
      logic [32:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             quad;
   } cordic_lane_type;

endpackage

/* sv/uvs_div_cell.sv */
// ----------------------------------------------------------------------------
// UV sphere divider cell
// One restoring quotient bit for the theta and phi lanes, registered.
// ----------------------------------------------------------------------------
module uvs_div_cell import uvs_pkg::*; (
   input  logic         clock,
   input  logic [7:0]   divisor_a,
   input  logic [7:0]   divisor_b,
   input  div_lane_type lane_a_in,
   input  div_lane_type lane_b_in,
   output div_lane_type lane_a_out,
   output div_lane_type lane_b_out
);

   div_lane_type lane_a_ff, lane_b_ff;
   div_lane_type next_a_in, next_b_in;

   function automatic div_lane_type div_step(div_lane_type lane, logic [7:0] divisor);
      logic [8:0]   shifted;
      div_lane_type res;
      shifted = {lane.rem, 1'b0};
      if (shifted >= {1'b0, divisor}) begin
         res.rem = 8'(shifted - {1'b0, divisor});
         res.quo = {lane.quo[31:0], 1'b1};
      end else begin
         res.rem = shifted[7:0];
         res.quo = {lane.quo[31:0], 1'b0};
      end
      return res;
   endfunction

   always_comb begin
      next_a_in = div_step(lane_a_in, divisor_a);
      next_b_in = div_step(lane_b_in, divisor_b);
   end

   always_ff @(posedge clock) begin
      lane_a_ff <= next_a_in;
      lane_b_ff <= next_b_in;
   end

   assign lane_a_out = lane_a_ff;
   assign lane_b_out = lane_b_ff;

endmodule

/* sv/uvs_cordic_cell.sv */
// ----------------------------------------------------------------------------
// UV sphere CORDIC cell
// One rotation-mode micro-rotation for the theta and phi lanes, registered.
// ----------------------------------------------------------------------------
module uvs_cordic_cell import uvs_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  cordic_lane_type lane_a_in,
   input  cordic_lane_type lane_b_in,
   output cordic_lane_type lane_a_out,
   output cordic_lane_type lane_b_out
);

   localparam logic signed [Z_W-1:0] ATAN = signed'({1'b0, ATAN_TABLE[STEP]});

   cordic_lane_type lane_a_ff, lane_b_ff;
   cordic_lane_type next_a_in, next_b_in;

   function automatic cordic_lane_type rotate(cordic_lane_type lane);
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      cordic_lane_type        res;
      dx = lane.y >>> STEP;
      dy = lane.x >>> STEP;
      res.quad = lane.quad;
      if (!lane.z[Z_W-1]) begin
         res.x = lane.x - dx;
         res.y = lane.y + dy;
         res.z = lane.z - ATAN;
      end else begin
         res.x = lane.x + dx;
         res.y = lane.y - dy;
         res.z = lane.z + ATAN;
      end
      return res;
   endfunction

   always_comb begin
      next_a_in = rotate(lane_a_in);
      next_b_in = rotate(lane_b_in);
   end

   always_ff @(posedge clock) begin
      lane_a_ff <= next_a_in;
      lane_b_ff <= next_b_in;
   end

   assign lane_a_out = lane_a_ff;
   assign lane_b_out = lane_b_ff;

endmodule

/* sv/uv_sphere_vertex_generator_top.sv */
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Maps one (stack, slice) grid point to position, texture, normal and index.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_stack_index / req_slice_index with start high; the item is taken
//   at that edge. busy is always low, so one item can enter every cycle.
//   Each item leaves as one result, shown on the rsp_ ports for one cycle with
//   rsp_valid high. Items stay in order.
//   Each item passes a 32-cell quotient chain (one bit per cell), then one
//   cell per CORDIC micro-rotation, then five stages for quadrant folding,
//   the normal products, rounding, radius scaling and saturation.
//   Throughput is one item per cycle.
//   The csr_ port writes radius (0), stack_count (1), slice_count (2); other
//   indexes are dropped. Write it only while no item is in flight.
//   Reset clears the in-flight valid bits and loads radius 1.0, 40 stacks and
//   40 slices. The receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_top_defines.svh"

module uv_sphere_vertex_generator_top import uvs_pkg::*; #(
   parameter int MAX_GRID     = 256,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_stack_index,
   input  logic [7:0]         req_slice_index,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [15:0]        rsp_vertex_index,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_starts_quad
);

   localparam int P   = CORDIC_STEPS;
   localparam int LAT = P + 38;

   typedef struct packed {
      logic [15:0] vidx;
      logic        quad;
   } side_type;

   typedef struct packed {
      logic [15:0] u;
      logic [15:0] v;
   } uv_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
   } cs_type;

   // configuration
   logic [15:0] radius_ff;
   logic [8:0]  stack_count_ff, slice_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         stack_count_ff <= 9'd40;
         slice_count_ff <= 9'd40;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIUS:      radius_ff      <= csr_wdata;
            CSR_STACK_COUNT: stack_count_ff <= csr_wdata[8:0];
            CSR_SLICE_COUNT: slice_count_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   function automatic logic [8:0] clamp_count(logic [8:0] n);
      if (n < 9'd2) return 9'd2;
      if (n > 9'(MAX_GRID)) return 9'(MAX_GRID);
      return n;
   endfunction

   logic [8:0] slices_c;
   logic [7:0] div_s, div_l, i_c, j_c;
   logic       accept;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign slices_c = clamp_count(slice_count_ff);
   assign div_s    = 8'(clamp_count(stack_count_ff) - 9'd1);
   assign div_l    = 8'(slices_c - 9'd1);
   assign i_c      = (req_stack_index > div_s) ? div_s : req_stack_index;
   assign j_c      = (req_slice_index > div_l) ? div_l : req_slice_index;

   // control pipeline and side data
   logic [LAT-1:0] vld_ff;
   side_type       side_ff [0:LAT-1];
   side_type       side_in;
   uv_type         uv_ff [0:P+4];
   uv_type         uv_in;

   always_comb begin
      logic [16:0] flat;
      flat         = 17'(i_c) * 17'(slices_c) + 17'(j_c);
      side_in.vidx = flat[15:0];
      side_in.quad = (i_c < div_s) && (j_c < div_l);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      uv_ff[0] <= uv_in;
      for (int k = 1; k <= P + 4; k++) begin
         uv_ff[k] <= uv_ff[k-1];
      end
   end

   // quotient chain: index << 32 over (count - 1)
   div_lane_type div_a [0:DIV_STEPS];
   div_lane_type div_b [0:DIV_STEPS];
   div_lane_type div_a_in, div_b_in;
   div_lane_type div_a_ff, div_b_ff;

   always_comb begin
      // index never exceeds the divisor, so the top quotient bit is index == divisor
      div_a_in.rem = (i_c == div_s) ? 8'd0 : i_c;
      div_a_in.quo = {32'd0, i_c == div_s};
      div_b_in.rem = (j_c == div_l) ? 8'd0 : j_c;
      div_b_in.quo = {32'd0, j_c == div_l};
   end

   always_ff @(posedge clock) begin
      div_a_ff <= div_a_in;
      div_b_ff <= div_b_in;
   end

   assign div_a[0] = div_a_ff;
   assign div_b[0] = div_b_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      uvs_div_cell u_cell (
         .clock      (clock),
         .divisor_a  (div_s),
         .divisor_b  (div_l),
         .lane_a_in  (div_a[k]),
         .lane_b_in  (div_b[k]),
         .lane_a_out (div_a[k+1]),
         .lane_b_out (div_b[k+1])
      );
   end

   // angles in 2^-32 turn; phi uses j << 31, i.e. the quotient shifted down once
   logic [31:0] theta, phi;
   assign theta = div_a[DIV_STEPS].quo[31:0];
   assign phi   = div_b[DIV_STEPS].quo[32:1];
   assign uv_in.u = div_a[DIV_STEPS].quo[32:17] + U_OFFSET;
   assign uv_in.v = div_b[DIV_STEPS].quo[32:17] + V_OFFSET;

   cordic_lane_type cor_t [0:P];
   cordic_lane_type cor_p [0:P];

   always_comb begin
      cor_t[0].x    = CORDIC_GAIN_INV;
      cor_t[0].y    = '0;
      cor_t[0].z    = signed'({3'b000, theta[29:0]});
      cor_t[0].quad = theta[31:30];
      cor_p[0].x    = CORDIC_GAIN_INV;
      cor_p[0].y    = '0;
      cor_p[0].z    = signed'({3'b000, phi[29:0]});
      cor_p[0].quad = phi[31:30];
   end

   for (genvar k = 0; k < P; k++) begin : g_cordic
      uvs_cordic_cell #(.STEP(k)) u_cell (
         .clock      (clock),
         .lane_a_in  (cor_t[k]),
         .lane_b_in  (cor_p[k]),
         .lane_a_out (cor_t[k+1]),
         .lane_b_out (cor_p[k+1])
      );
   end

   function automatic cs_type fold(cordic_lane_type lane);
      cs_type res;
      case (lane.quad)
         2'd0: begin
            res.c = 32'(lane.x);
            res.s = 32'(lane.y);
         end
         2'd1: begin
            res.c = 32'(-lane.y);
            res.s = 32'(lane.x);
         end
         2'd2: begin
            res.c = 32'(-lane.x);
            res.s = 32'(-lane.y);
         end
         default: begin
            res.c = 32'(lane.y);
            res.s = 32'(-lane.x);
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [15:0] sat_normal(logic signed [31:0] n);
      logic signed [33:0] t;
      t = (34'(n) + 34'sd16384) >>> 15;
      if (t > 34'sd32767) return 16'sd32767;
      if (t < -34'sd32767) return -16'sd32767;
      return 16'(t);
   endfunction

   function automatic logic signed [16:0] sat_pos(logic signed [48:0] m);
      logic signed [48:0] t;
      t = (m + 49'sd536870912) >>> 30;
      if (t > 49'sd65535) return 17'sd65535;
      if (t < -49'sd65535) return -17'sd65535;
      return 17'(t);
   endfunction

   // quadrant fold
   cs_type tcs_ff, pcs_ff;
   always_ff @(posedge clock) begin
      tcs_ff <= fold(cor_t[P]);
      pcs_ff <= fold(cor_p[P]);
   end

   // cos*sin products
   logic signed [63:0] px_ff, py_ff;
   logic signed [31:0] cp2_ff;
   always_ff @(posedge clock) begin
      px_ff  <= tcs_ff.c * pcs_ff.s;
      py_ff  <= tcs_ff.s * pcs_ff.s;
      cp2_ff <= pcs_ff.c;
   end

   // round to Q30, normals
   logic signed [31:0] nx_in, ny_in;
   logic signed [31:0] nx_ff, ny_ff, cp3_ff;
   logic signed [15:0] nrm_x_ff, nrm_y_ff, nrm_z_ff;
   logic signed [15:0] nrm2_x_ff, nrm2_y_ff, nrm2_z_ff;
   assign nx_in = 32'((px_ff + 64'sd536870912) >>> 30);
   assign ny_in = 32'((py_ff + 64'sd536870912) >>> 30);

   always_ff @(posedge clock) begin
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      cp3_ff   <= cp2_ff;
      nrm_x_ff <= sat_normal(nx_in);
      nrm_y_ff <= sat_normal(ny_in);
      nrm_z_ff <= sat_normal(cp2_ff);
   end

   // radius scaling
   logic signed [16:0] radius_s;
   logic signed [48:0] mx_ff, my_ff, mz_ff;
   assign radius_s = signed'({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      mx_ff     <= nx_ff * radius_s;
      my_ff     <= ny_ff * radius_s;
      mz_ff     <= cp3_ff * radius_s;
      nrm2_x_ff <= nrm_x_ff;
      nrm2_y_ff <= nrm_y_ff;
      nrm2_z_ff <= nrm_z_ff;
   end

   // output stage
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] out_nx_ff, out_ny_ff, out_nz_ff;
   always_ff @(posedge clock) begin
      pos_x_ff  <= sat_pos(mx_ff);
      pos_y_ff  <= sat_pos(my_ff);
      pos_z_ff  <= sat_pos(mz_ff);
      out_nx_ff <= nrm2_x_ff;
      out_ny_ff <= nrm2_y_ff;
      out_nz_ff <= nrm2_z_ff;
   end

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_vertex_index = side_ff[LAT-1].vidx;
   assign rsp_starts_quad  = side_ff[LAT-1].quad;
   assign rsp_tex_u        = uv_ff[P+4].u;
   assign rsp_tex_v        = uv_ff[P+4].v;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_normal_x     = out_nx_ff;
   assign rsp_normal_y     = out_ny_ff;
   assign rsp_normal_z     = out_nz_ff;

   `UVS_ASSERT_IMPLY(a_result_has_item, rsp_valid, $past(accept, LAT))
   `UVS_ASSERT_NEVER(a_normal_saturated, rsp_valid && (rsp_normal_x == 16'sh8000 || rsp_normal_y == 16'sh8000 || rsp_normal_z == 16'sh8000))
   `UVS_ASSERT_NEVER(a_pos_saturated, rsp_valid && (rsp_pos_x == 17'sh10000 || rsp_pos_y == 17'sh10000 || rsp_pos_z == 17'sh10000))
   `UVS_ASSERT_IMPLY(a_tex_offset, rsp_valid, rsp_tex_u >= U_OFFSET && rsp_tex_v >= V_OFFSET)

endmodule

/* sim/tb_uv_sphere_vertex_generator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Streams grid points through the block under several radius and grid-count
// settings, predicts each vertex with a bit-exact CORDIC model and checks every
// result field in order of arrival.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator_top import uvs_pkg::*;;

   localparam int          STEPS       = 16;
   localparam int          GRID_MAX    = 256;
   localparam int          SETTLE      = 60;
   localparam int          CYCLE_LIMIT = 300000;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;

   typedef enum {OP_VERTEX, OP_CSR, OP_DRAIN, OP_IDLE} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [7:0]  i;
      logic [7:0]  j;
      logic [1:0]  idx;
      logic [15:0] data;
      int          pct;
   } op_type;

   typedef struct packed {
      logic [15:0]        vertex_index;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               starts_quad;
   } vertex_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_stack_index;
   logic [7:0]         req_slice_index;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               rsp_valid;
   logic [15:0]        rsp_vertex_index;
   logic signed [16:0] rsp_pos_x;
   logic signed [16:0] rsp_pos_y;
   logic signed [16:0] rsp_pos_z;
   logic [15:0]        rsp_tex_u;
   logic [15:0]        rsp_tex_v;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_starts_quad;

   op_type      pending_ops[$];
   vertex_type  vertex_queue[$];
   logic [15:0] cur_radius;
   logic [8:0]  cur_stacks;
   logic [8:0]  cur_slices;
   int          sender_idle_pct;
   int          quiet_cycles;
   int          err_count;
   int          cycle_count;
   bit          stim_done;

   uv_sphere_vertex_generator_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_grid(longint n);
      if (n < 2) return 2;
      if (n > GRID_MAX) return GRID_MAX;
      return n;
   endfunction

   function automatic longint round_q(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint sat(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // rotation-mode CORDIC, angle in 2^-32 turn, results in Q2.30
   function automatic void cordic_sincos(logic [31:0] a, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = CORDIC_GAIN_INV;
      y = 0;
      z = longint'(a[29:0]);
      for (int k = 0; k < STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TABLE[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TABLE[k]);
         end
      end
      case (a[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic vertex_type compute_vertex(logic [7:0] si, logic [7:0] sj);
      vertex_type v;
      longint s_n, l_n, i, j, r, ct, st, cp, sp, nx, ny;
      logic [31:0] theta, phi;
      s_n = clamp_grid(cur_stacks);
      l_n = clamp_grid(cur_slices);
      i = (si > s_n - 1) ? s_n - 1 : si;
      j = (sj > l_n - 1) ? l_n - 1 : sj;
      r = cur_radius;
      theta = 32'(longint'((i << 32) / (s_n - 1)));   // full turn wraps to zero
      phi   = 32'((j << 31) / (l_n - 1));
      cordic_sincos(theta, ct, st);
      cordic_sincos(phi, cp, sp);
      nx = round_q(ct * sp, 30);
      ny = round_q(st * sp, 30);
      v.vertex_index = 16'(i * l_n + j);
      v.pos_x        = 17'(sat(round_q(nx * r, 30), 65535));
      v.pos_y        = 17'(sat(round_q(ny * r, 30), 65535));
      v.pos_z        = 17'(sat(round_q(cp * r, 30), 65535));
      v.tex_u        = 16'((i * 32768) / (s_n - 1)) + U_OFFSET;
      v.tex_v        = 16'((j * 32768) / (l_n - 1)) + V_OFFSET;
      v.normal_x     = 16'(sat(round_q(nx, 15), 32767));
      v.normal_y     = 16'(sat(round_q(ny, 15), 32767));
      v.normal_z     = 16'(sat(round_q(cp, 15), 32767));
      v.starts_quad  = (i < s_n - 1) && (j < l_n - 1);
      return v;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
      err_count++;
   endtask

   task automatic add_vertex(int i, int j);
      op_type op;
      op.kind = OP_VERTEX; op.i = 8'(i); op.j = 8'(j);
      pending_ops = {pending_ops, op};
   endtask

   task automatic add_csr(logic [1:0] idx, int data);
      op_type op;
      op.kind = OP_CSR; op.idx = idx; op.data = 16'(data);
      pending_ops = {pending_ops, op};
   endtask

   task automatic add_marker(op_kind_type kind, int pct);
      op_type op;
      op.kind = kind; op.pct = pct;
      pending_ops = {pending_ops, op};
   endtask

   // stimulus plan
   initial begin
      int s_n, l_n, r;
      add_marker(OP_IDLE, 15);
      // default grid: corners, clamping, the wrap at the full turn
      add_vertex(0, 0);     add_vertex(39, 39);   add_vertex(255, 255);
      add_vertex(0, 255);   add_vertex(38, 38);   add_vertex(20, 10);
      add_vertex(10, 20);   add_vertex(30, 5);
      add_csr(CSR_RADIUS, 16'hFFFF);
      add_csr(CSR_STACK_COUNT, 2);
      add_csr(CSR_SLICE_COUNT, 2);
      add_vertex(0, 0);     add_vertex(1, 1);     add_vertex(0, 1);   add_vertex(170, 85);
      add_csr(CSR_RADIUS, 0);
      add_csr(CSR_STACK_COUNT, 256);
      add_csr(CSR_SLICE_COUNT, 9'h1FF);     // clamps to the grid maximum
      add_vertex(255, 255); add_vertex(128, 64);  add_vertex(64, 128);
      add_csr(CSR_UNUSED, 16'h5555);        // dropped write
      add_csr(CSR_RADIUS, 16'h7F80);
      add_csr(CSR_STACK_COUNT, 0);          // clamps up to two
      add_csr(CSR_SLICE_COUNT, 1);
      add_vertex(1, 0);     add_vertex(0, 1);     add_vertex(255, 0);
      add_csr(CSR_SLICE_COUNT, 256);
      add_vertex(1, 127);   add_vertex(0, 200);

      for (int phase = 0; phase < 3; phase++) begin
         add_marker(OP_IDLE, phase == 0 ? 15 : (phase == 1 ? 67 : 0));
         for (int blk = 0; blk < 4; blk++) begin
            case ($urandom_range(0, 3))
               0: r = 0;
               1: r = 16'hFFFF;
               default: r = $urandom_range(1, 65535);
            endcase
            s_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 24);
            l_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 24);
            add_csr(CSR_RADIUS, r);
            add_csr(CSR_STACK_COUNT, s_n);
            add_csr(CSR_SLICE_COUNT, l_n);
            s_n = int'(clamp_grid(9'(s_n)));
            l_n = int'(clamp_grid(9'(l_n)));
            for (int n = 0; n < 33; n++) begin
               if (n == 16 && blk == 1) add_marker(OP_DRAIN, 0);
               if ($urandom_range(0, 99) < 85)
                  add_vertex($urandom_range(0, s_n - 1), $urandom_range(0, l_n - 1));
               else
                  add_vertex($urandom_range(0, 255), $urandom_range(0, 255));
            end
         end
      end
   end

   // driver: config writes and drain points wait for a quiet pipeline
   always @(posedge clock) begin
      logic       nxt_start;
      logic       nxt_we;
      logic [7:0] nxt_i;
      logic [7:0] nxt_j;
      logic [1:0] nxt_idx;
      logic [15:0] nxt_data;
      bit         accepted;
      bit         hold;
      if (reset) begin
         start           <= 1'b0;
         csr_we          <= 1'b0;
         req_stack_index <= '0;
         req_slice_index <= '0;
         csr_index       <= CSR_RADIUS;
         csr_wdata       <= '0;
         cur_radius       = 16'd256;
         cur_stacks       = 9'd40;
         cur_slices       = 9'd40;
         quiet_cycles     = 0;
         stim_done       <= 1'b0;
         sender_idle_pct  = 15;
      end else begin
         accepted = start && !busy;
         hold     = start && busy;
         if (accepted)
            vertex_queue = {vertex_queue, compute_vertex(req_stack_index, req_slice_index)};
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS:      cur_radius = csr_wdata;
               CSR_STACK_COUNT: cur_stacks = csr_wdata[8:0];
               CSR_SLICE_COUNT: cur_slices = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (vertex_queue.size() == 0 && !start) quiet_cycles = quiet_cycles + 1;
         else quiet_cycles = 0;

         nxt_start = hold;
         nxt_we    = 1'b0;
         nxt_i     = req_stack_index;
         nxt_j     = req_slice_index;
         nxt_idx   = csr_index;
         nxt_data  = csr_wdata;
         while (!hold && pending_ops.size() > 0 && pending_ops[0].kind == OP_IDLE)
            sender_idle_pct = pending_ops.pop_front().pct;
         if (!hold && pending_ops.size() > 0) begin
            case (pending_ops[0].kind)
               OP_VERTEX: begin
                  if ($urandom_range(0, 99) >= sender_idle_pct) begin
                     nxt_start = 1'b1;
                     nxt_i     = pending_ops[0].i;
                     nxt_j     = pending_ops[0].j;
                     void'(pending_ops.pop_front());
                  end
               end
               OP_CSR: begin
                  if (!start && quiet_cycles >= SETTLE) begin
                     nxt_we   = 1'b1;
                     nxt_idx  = pending_ops[0].idx;
                     nxt_data = pending_ops[0].data;
                     void'(pending_ops.pop_front());
                  end
               end
               default: begin
                  if (!start && quiet_cycles >= SETTLE) void'(pending_ops.pop_front());
               end
            endcase
         end
         if (!hold && !nxt_start && pending_ops.size() == 0) stim_done <= 1'b1;
         start           <= nxt_start;
         csr_we          <= nxt_we;
         req_stack_index <= nxt_i;
         req_slice_index <= nxt_j;
         csr_index       <= nxt_idx;
         csr_wdata       <= nxt_data;
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid) begin
         if (vertex_queue.size() == 0) begin
            report_mismatch("unexpected item, vertex_index", rsp_vertex_index, -1);
         end else begin
            want = vertex_queue.pop_front();
            if (rsp_vertex_index !== want.vertex_index)
               report_mismatch("vertex_index", rsp_vertex_index, want.vertex_index);
            if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
            if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
            if (rsp_pos_z !== want.pos_z) report_mismatch("pos_z", rsp_pos_z, want.pos_z);
            if (rsp_tex_u !== want.tex_u) report_mismatch("tex_u", rsp_tex_u, want.tex_u);
            if (rsp_tex_v !== want.tex_v) report_mismatch("tex_v", rsp_tex_v, want.tex_v);
            if (rsp_normal_x !== want.normal_x)
               report_mismatch("normal_x", rsp_normal_x, want.normal_x);
            if (rsp_normal_y !== want.normal_y)
               report_mismatch("normal_y", rsp_normal_y, want.normal_y);
            if (rsp_normal_z !== want.normal_z)
               report_mismatch("normal_z", rsp_normal_z, want.normal_z);
            if (rsp_starts_quad !== want.starts_quad)
               report_mismatch("starts_quad", rsp_starts_quad, want.starts_quad);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** uv_sphere_vertex_generator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      err_count   = 0;
      cycle_count = 0;
      start           <= 1'b0;
      csr_we          <= 1'b0;
      req_stack_index <= '0;
      req_slice_index <= '0;
      csr_index       <= CSR_RADIUS;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!(stim_done && vertex_queue.size() == 0));
      repeat (SETTLE) @(posedge clock);
      if (vertex_queue.size() != 0)
         report_mismatch("items left over", vertex_queue.size(), 0);
      if (err_count == 0)
         $display("** uv_sphere_vertex_generator_top: PASSED **");
      else
         $display("** uv_sphere_vertex_generator_top: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/uvs_pkg.sv
sv/uvs_div_cell.sv
sv/uvs_cordic_cell.sv
sv/uv_sphere_vertex_generator_top.sv
sim/tb_uv_sphere_vertex_generator_top.sv
